// ----- rtl/sau_pkg.sv -----
// ----------------------------------------------------------------------------
// sau_pkg
// shared sizes, operation codes and status codes of the stack arithmetic unit
// ----------------------------------------------------------------------------
package sau_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int WORD_WIDTH  = 32;

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ITER_W = $clog2(WORD_WIDTH + 1);

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_MOD  = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_TOO_FEW = 2'd2;
  localparam logic [1:0] ST_DIV0    = 2'd3;

  typedef struct packed {
    word_t quotient;
    word_t remainder;
    logic  done;
  } div_result_t;

endpackage

// ----- rtl/sau_div.sv -----
// ----------------------------------------------------------------------------
// sau_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sau_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  sau_pkg::word_t       dividend,
  input  sau_pkg::word_t       divisor,
  output sau_pkg::div_result_t result
);

  logic                               busy;
  logic                               done;
  logic [sau_pkg::ITER_W-1:0]         iter;
  sau_pkg::word_t                     rem;
  sau_pkg::word_t                     quo;
  sau_pkg::word_t                     den;
  logic [sau_pkg::WORD_WIDTH:0]       rem_shift;
  logic [sau_pkg::WORD_WIDTH:0]       rem_diff;
  logic                               take;

  always_comb begin
    rem_shift = {rem, quo[sau_pkg::WORD_WIDTH-1]};
    rem_diff  = rem_shift - {1'b0, den};
    take      = (rem_shift >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= sau_pkg::ITER_W'(sau_pkg::WORD_WIDTH);
      end else if (busy) begin
        iter <= iter - sau_pkg::ITER_W'(1);
        if (iter == sau_pkg::ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (busy) begin
      rem <= take ? rem_diff[sau_pkg::WORD_WIDTH-1:0] : rem_shift[sau_pkg::WORD_WIDTH-1:0];
      quo <= {quo[sau_pkg::WORD_WIDTH-2:0], take};
    end
  end

  assign result.quotient  = quo;
  assign result.remainder = rem;
  assign result.done      = done;

endmodule

// ----- rtl/stack_arithmetic_unit_top.sv -----
// ----------------------------------------------------------------------------
// stack_arithmetic_unit_top
// operand stack in a synchronous memory with an attached arithmetic unit
// ----------------------------------------------------------------------------
// One item at a time. Push, the unused op codes and a refused op go straight
// to the response state. Add, subtract and multiply pass through the execute
// state (one memory read of the second operand, the top operand is held in a
// register), a zero divisor adds a reload state (an extra read to refill the
// top register), and divide and modulo then wait in the divide state for the
// bit-serial divider. The finished result sits in an output register, so a
// stalled result holds the unit only when the next result is ready to leave.
module stack_arithmetic_unit_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         op,
  input  logic signed [31:0] push_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] top_value,
  output logic [6:0]         entry_count
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_RELOAD = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0]           state;
  logic [2:0]           op_q;
  logic [1:0]           status_q;
  sau_pkg::cnt_t        count;
  sau_pkg::word_t       top;
  logic                 q_neg;
  logic                 r_neg;

  sau_pkg::word_t       mem [sau_pkg::STACK_DEPTH];
  sau_pkg::word_t       rdata;
  sau_pkg::addr_t       ra;
  sau_pkg::addr_t       wa;
  sau_pkg::word_t       wd;
  logic                 we;

  sau_pkg::cnt_t        cnt_m1;
  sau_pkg::cnt_t        cnt_m2;
  sau_pkg::cnt_t        cnt_m3;
  logic                 accept;
  logic                 full;
  logic                 out_free;
  sau_pkg::word_t       push_word;
  sau_pkg::word_t       opa;
  sau_pkg::word_t       opb;
  sau_pkg::word_t       mag_a;
  sau_pkg::word_t       mag_b;
  sau_pkg::word_t       alu_res;
  sau_pkg::word_t       div_res;
  logic                 div_start;
  sau_pkg::div_result_t div_out;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign full      = (count >= sau_pkg::CNT_W'(sau_pkg::STACK_DEPTH));
  assign out_free  = !out_valid || !out_stall;
  assign cnt_m1    = count - sau_pkg::CNT_W'(1);
  assign cnt_m2    = count - sau_pkg::CNT_W'(2);
  assign cnt_m3    = count - sau_pkg::CNT_W'(3);
  assign push_word = sau_pkg::WORD_WIDTH'(push_value);

  assign opa   = rdata;
  assign opb   = top;
  assign mag_a = opa[sau_pkg::WORD_WIDTH-1] ? (sau_pkg::word_t'(0) - opa) : opa;
  assign mag_b = opb[sau_pkg::WORD_WIDTH-1] ? (sau_pkg::word_t'(0) - opb) : opb;

  always_comb begin
    case (op_q)
      sau_pkg::OP_ADD: alu_res = opa + opb;
      sau_pkg::OP_SUB: alu_res = opa - opb;
      default:         alu_res = sau_pkg::WORD_WIDTH'(opa * opb);
    endcase
  end

  always_comb begin
    if (op_q == sau_pkg::OP_DIV) begin
      div_res = q_neg ? (sau_pkg::word_t'(0) - div_out.quotient) : div_out.quotient;
    end else begin
      div_res = r_neg ? (sau_pkg::word_t'(0) - div_out.remainder) : div_out.remainder;
    end
  end

  assign div_start = (state == S_EXEC) && (op_q inside {sau_pkg::OP_DIV, sau_pkg::OP_MOD})
                     && (opb != '0);

  sau_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag_a),
    .divisor  (mag_b),
    .result   (div_out)
  );

  // memory port selection
  always_comb begin
    we = 1'b0;
    wa = count[sau_pkg::ADDR_W-1:0];
    wd = push_word;
    ra = cnt_m2[sau_pkg::ADDR_W-1:0];
    case (state)
      S_IDLE: begin
        we = accept && (op == sau_pkg::OP_PUSH) && !full;
      end
      S_EXEC: begin
        ra = cnt_m3[sau_pkg::ADDR_W-1:0];
        wa = cnt_m2[sau_pkg::ADDR_W-1:0];
        wd = alu_res;
        we = (op_q inside {sau_pkg::OP_ADD, sau_pkg::OP_SUB, sau_pkg::OP_MUL});
      end
      S_DIV: begin
        wa = cnt_m2[sau_pkg::ADDR_W-1:0];
        wd = div_res;
        we = div_out.done;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (op)
              sau_pkg::OP_PUSH: begin
                state <= S_RESP;
                if (!full) begin
                  count <= count + sau_pkg::CNT_W'(1);
                end
              end
              sau_pkg::OP_ADD, sau_pkg::OP_SUB, sau_pkg::OP_MUL,
              sau_pkg::OP_DIV, sau_pkg::OP_MOD: begin
                if (!full && count >= sau_pkg::CNT_W'(2)) begin
                  state <= S_EXEC;
                end else begin
                  state <= S_RESP;
                end
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_EXEC: begin
          if (op_q inside {sau_pkg::OP_ADD, sau_pkg::OP_SUB, sau_pkg::OP_MUL}) begin
            count <= cnt_m1;
            state <= S_RESP;
          end else if (opb == '0) begin
            count <= cnt_m2;
            state <= S_RELOAD;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_out.done) begin
            count <= cnt_m1;
            state <= S_RESP;
          end
        end
        S_RELOAD: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op_q <= op;
          case (op)
            sau_pkg::OP_PUSH: begin
              if (full) begin
                status_q <= sau_pkg::ST_FULL;
              end else begin
                status_q <= sau_pkg::ST_OK;
                top      <= push_word;
              end
            end
            sau_pkg::OP_ADD, sau_pkg::OP_SUB, sau_pkg::OP_MUL,
            sau_pkg::OP_DIV, sau_pkg::OP_MOD: begin
              if (full) begin
                status_q <= sau_pkg::ST_FULL;
              end else if (count < sau_pkg::CNT_W'(2)) begin
                status_q <= sau_pkg::ST_TOO_FEW;
              end else begin
                status_q <= sau_pkg::ST_OK;
              end
            end
            default: begin
              status_q <= sau_pkg::ST_OK;
            end
          endcase
        end
      end
      S_EXEC: begin
        q_neg <= opa[sau_pkg::WORD_WIDTH-1] ^ opb[sau_pkg::WORD_WIDTH-1];
        r_neg <= opa[sau_pkg::WORD_WIDTH-1];
        if (op_q inside {sau_pkg::OP_ADD, sau_pkg::OP_SUB, sau_pkg::OP_MUL}) begin
          top <= alu_res;
        end else if (opb == '0) begin
          status_q <= sau_pkg::ST_DIV0;
        end
      end
      S_DIV: begin
        if (div_out.done) begin
          top <= div_res;
        end
      end
      S_RELOAD: begin
        top <= rdata;
      end
      S_RESP: begin
        if (out_free) begin
          status      <= status_q;
          top_value   <= (count == '0) ? 32'sd0 : 32'(signed'(top));
          entry_count <= 7'(count);
        end
      end
      default: begin
        top <= top;
      end
    endcase
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sau_pkg::CNT_W'(sau_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("item accepted without leaving idle");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_out.done |-> (state == S_DIV))
    else $error("divider finished outside divide state");

  a_write_below_top: assert property (@(posedge clk) disable iff (rst)
    we |-> (sau_pkg::CNT_W'(wa) <= count))
    else $error("memory write above stack top");

  a_resp_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && out_valid && out_stall) |=> (state == S_RESP))
    else $error("result overwritten while output stalled");

endmodule
